FILE: hw/rtl/atr_pkg.sv
// ----------------------------------------------------------------------------
// ATR parser package
// Beat payload types, byte kind codes, parse phase codes and limits shared by
// the stream interface users and the parser.
// ----------------------------------------------------------------------------
package atr_pkg;

  // Interface levels walked through TD1 and TD2
  localparam int MAX_LEVELS = 3;

  localparam int COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Byte kinds
  localparam logic [2:0] KIND_TS      = 3'd0;
  localparam logic [2:0] KIND_T0      = 3'd1;
  localparam logic [2:0] KIND_TA      = 3'd2;
  localparam logic [2:0] KIND_TB      = 3'd3;
  localparam logic [2:0] KIND_TC      = 3'd4;
  localparam logic [2:0] KIND_TD      = 3'd5;
  localparam logic [2:0] KIND_TRAIL   = 3'd6;
  localparam logic [2:0] KIND_IGNORED = 3'd7;

  // Parse phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_T0    = 2'd1;
  localparam logic [1:0] PH_IFACE = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  // Interface byte slots within one level
  localparam logic [1:0] SLOT_TA = 2'd0;
  localparam logic [1:0] SLOT_TB = 2'd1;
  localparam logic [1:0] SLOT_TC = 2'd2;
  localparam logic [1:0] SLOT_TD = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } atr_byte_t;

  typedef struct packed {
    logic [2:0]         byte_kind;
    logic [COUNT_W-1:0] byte_position;
    logic               frame_done;
    logic [COUNT_W-1:0] frame_length;
    logic [7:0]         captured_ta1;
    logic [7:0]         captured_td1;
    logic [7:0]         captured_tc3;
    logic [3:0]         protocol_type;
  } atr_result_t;

endpackage

FILE: hw/rtl/atr_stream_if.sv
// ----------------------------------------------------------------------------
// ATR stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface atr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/smartcard_atr_parser_top.sv
// The result beat is registered and appears in the cycle after its byte beat is accepted.
// Throughput: one byte per cycle; the result register takes a new beat whenever
//   it is empty or its beat is taken in the same cycle.
// Reset (rst, synchronous): phase goes to expect-TS, counts and captures clear,
//   the result register empties.
// ----------------------------------------------------------------------------
// Smart card ATR parser
// Classifies each answer-to-reset byte (TS, T0, TA/TB/TC/TD, trailing), tracks
// the frame length and captures TA1, TD1 and TC3.
// ----------------------------------------------------------------------------
module smartcard_atr_parser_top (
  input  logic          clk,
  input  logic          rst,
  atr_stream_if.sink    bytes,
  atr_stream_if.source  results
);
  import atr_pkg::*;

  logic [1:0]         phase, phase_next;
  logic [3:0]         presence, presence_next;
  logic [1:0]         level, level_next;
  logic [4:0]         trailing_left, trailing_left_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         ta1, ta1_next;
  logic [7:0]         td1, td1_next;
  logic [7:0]         tc3, tc3_next;

  logic               out_valid;
  atr_result_t        out_beat, out_beat_next;

  logic               accept;
  logic [7:0]         b;
  logic [1:0]         slot;
  logic [3:0]         presence_cleared;
  logic [COUNT_W-1:0] count_inc;
  logic [2:0]         kind;
  logic [COUNT_W-1:0] pos;
  logic               done;
  logic [4:0]         trail_dec;

  assign bytes.ready   = !out_valid || results.ready;
  assign accept        = bytes.valid && bytes.ready;
  assign results.valid = out_valid;
  assign results.payload = out_beat;

  assign b         = bytes.payload.rx_byte;
  assign count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;

  // Lowest pending slot; TD when none of TA..TC is pending
  always_comb begin
    if (presence[0]) begin
      slot = SLOT_TA;
    end else if (presence[1]) begin
      slot = SLOT_TB;
    end else if (presence[2]) begin
      slot = SLOT_TC;
    end else begin
      slot = SLOT_TD;
    end
  end

  assign presence_cleared = presence & ~(4'b0001 << slot);
  assign trail_dec = (trailing_left != 5'd0) ? trailing_left - 5'd1 : trailing_left;

  always_comb begin
    phase_next         = phase;
    presence_next      = presence;
    level_next         = level;
    trailing_left_next = trailing_left;
    byte_count_next    = byte_count;
    ta1_next           = ta1;
    td1_next           = td1;
    tc3_next           = tc3;
    kind               = KIND_IGNORED;
    pos                = byte_count;
    done               = 1'b0;

    if (bytes.payload.frame_start) begin
      presence_next      = 4'd0;
      level_next         = 2'd0;
      trailing_left_next = 5'd0;
      ta1_next           = 8'd0;
      td1_next           = 8'd0;
      tc3_next           = 8'd0;
      byte_count_next    = COUNT_W'(1);
      pos                = '0;
      kind               = KIND_TS;
      phase_next         = PH_T0;
    end else begin
      case (phase)
        PH_T0: begin
          kind               = KIND_T0;
          byte_count_next    = count_inc;
          trailing_left_next = {1'b0, b[3:0]} + 5'd1;
          presence_next      = b[7:4];
          level_next         = 2'd0;
          phase_next         = (b[7:4] != 4'd0) ? PH_IFACE : PH_TRAIL;
        end
        PH_IFACE: begin
          byte_count_next = count_inc;
          presence_next   = presence_cleared;
          case (slot)
            SLOT_TA: kind = KIND_TA;
            SLOT_TB: kind = KIND_TB;
            SLOT_TC: kind = KIND_TC;
            default: kind = KIND_TD;
          endcase
          if (slot == SLOT_TA && level == 2'd0) begin
            ta1_next = b;
          end
          if (slot == SLOT_TC && level == 2'd2) begin
            tc3_next = b;
          end
          if (slot == SLOT_TD) begin
            if (level == 2'd0) begin
              td1_next = b;
            end
            // Deepest level: ignore its TD presence bits
            if (({1'b0, level} + 3'd1) < 3'(MAX_LEVELS)) begin
              level_next    = level + 2'd1;
              presence_next = b[7:4];
            end else begin
              presence_next = 4'd0;
            end
          end
          if (presence_next == 4'd0) begin
            phase_next = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          kind               = KIND_TRAIL;
          byte_count_next    = count_inc;
          trailing_left_next = trail_dec;
          if (trail_dec == 5'd0) begin
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_beat_next.byte_kind     = kind;
    out_beat_next.byte_position = pos;
    out_beat_next.frame_done    = done;
    out_beat_next.frame_length  = byte_count_next;
    out_beat_next.captured_ta1  = ta1_next;
    out_beat_next.captured_td1  = td1_next;
    out_beat_next.captured_tc3  = tc3_next;
    out_beat_next.protocol_type = td1_next[4] ? 4'd0 : td1_next[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      presence      <= 4'd0;
      level         <= 2'd0;
      trailing_left <= 5'd0;
      byte_count    <= '0;
      ta1           <= 8'd0;
      td1           <= 8'd0;
      tc3           <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (bytes.ready) begin
        out_valid <= bytes.valid;
      end
      if (accept) begin
        phase         <= phase_next;
        presence      <= presence_next;
        level         <= level_next;
        trailing_left <= trailing_left_next;
        byte_count    <= byte_count_next;
        ta1           <= ta1_next;
        td1           <= td1_next;
        tc3           <= tc3_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat <= out_beat_next;
    end
  end

  a_done_is_trailing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.frame_done) |-> (out_beat.byte_kind == KIND_TRAIL))
    else $error("frame_done on a non-trailing byte");

  a_start_to_t0: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes.payload.frame_start) |=> (phase == PH_T0))
    else $error("start mark did not open a frame");

  a_ts_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.byte_kind == KIND_TS) |->
      (out_beat.byte_position == '0 && out_beat.frame_length == COUNT_W'(1)))
    else $error("TS beat with wrong position or length");

  a_trail_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAIL) |-> (trailing_left != 5'd0))
    else $error("trailing phase with no trailing bytes left");

  a_iface_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IFACE) |-> (presence != 4'd0))
    else $error("interface phase with no interface bytes pending");

endmodule
